// ===== rtl/bfst_pkg.sv =====
// Shared types, constants and helpers of the byte frequency sorted table.
package bfst_pkg;

  localparam int COUNT_BITS = 16;
  localparam int SYMBOLS    = 256;
  localparam int SYM_W      = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
  localparam int IDX_W      = $clog2(SYMBOLS + 1);
  localparam int KEY_W      = COUNT_BITS + SYM_W;

  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  localparam logic ACT_COUNT = 1'b0;
  localparam logic ACT_EMIT  = 1'b1;

  typedef struct packed {
    logic       action;
    logic [7:0] byte_value;
  } bfst_in_t;

  typedef struct packed {
    logic [7:0]  symbol;
    logic [15:0] count;
    logic        valid_res;
    logic        last;
  } bfst_out_t;

  typedef enum logic [1:0] {
    OP_COUNT,
    OP_EMIT,
    OP_RESTART
  } bfst_op_kind_t;

  typedef struct packed {
    bfst_op_kind_t    kind;
    logic [SYM_W-1:0] sym;
  } bfst_op_t;

  // low 16 bits of a counter, zero-extended when the counter is narrower
  function automatic logic [15:0] cnt_field(input logic [COUNT_BITS-1:0] c);
    logic [31:0] wide;
    wide = 32'(c);
    return wide[15:0];
  endfunction

  function automatic logic [7:0] sym_field(input logic [SYM_W-1:0] s);
    return 8'(s);
  endfunction

endpackage

// ===== rtl/byte_frequency_sorted_table_unit.sv =====
// Top level of the byte frequency sorted table (Huffman frequency stage).
//
// Count transactions bump a saturating per-byte counter (byte 0 and bytes
// beyond the table only restart the walk); emit transactions return the
// symbols with a nonzero count in ascending order of count, ties by byte
// value, one per emit, with last marking the final one and valid_res = 0
// once none remain. Any count transaction restarts the walk. The front end
// takes one transaction per cycle into a two-entry operation queue, so full
// only rises when the back end falls behind. In the back end a counted byte
// is read, then written back through the count table's separate write port;
// an ignored byte only clears the walk position; an emit takes the operation,
// reads the counters of bytes 1 to SYMBOLS - 1 through the table's one read
// port, drains the read stage, and loads the output register.
// The scan tracks the two smallest keys above the last emitted entry.
// Results sit in an output register, so counts go on while a result waits
// for pop; a finished scan holds in its last cycle until the register frees.
// The table needs no clearing pass: per-entry valid bits cleared by reset
// make unwritten counters read as zero.
module byte_frequency_sorted_table_unit
  import bfst_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  output logic      full,
  input  bfst_in_t  in_data,
  output logic      empty,
  input  logic      pop,
  output bfst_out_t out_data
);

  logic     op_valid;
  bfst_op_t op;
  logic     op_pop;
  logic     out_vld;

  bfst_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .op_valid (op_valid),
    .op       (op),
    .op_pop   (op_pop)
  );

  bfst_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .op_valid (op_valid),
    .op       (op),
    .op_pop   (op_pop),
    .out_vld  (out_vld),
    .out_res  (out_data),
    .out_pop  (pop)
  );

  assign empty = !out_vld;

endmodule

// ===== rtl/bfst_front.sv =====
// Front end: accepts input transactions, classifies them and queues the operations.
module bfst_front
  import bfst_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  output logic     full,
  input  bfst_in_t in_data,
  output logic     op_valid,
  output bfst_op_t op,
  input  logic     op_pop
);

  localparam int QDEPTH = 2;

  bfst_op_t   q_r [QDEPTH];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] fill_r, fill_nxt;
  logic       push_ok;
  logic       pop_ok;
  bfst_op_t   cls;

  // decode: emit, a real count, or a byte that only restarts the walk
  always_comb begin
    cls.sym  = in_data.byte_value[SYM_W-1:0];
    if (in_data.action == ACT_EMIT) begin
      cls.kind = OP_EMIT;
    end else if ((in_data.byte_value != 8'd0) &&
                 (9'(in_data.byte_value) < 9'(SYMBOLS))) begin
      cls.kind = OP_COUNT;
    end else begin
      cls.kind = OP_RESTART;
    end
  end

  assign full     = (fill_r == 2'(QDEPTH));
  assign op_valid = (fill_r != 2'd0);
  assign op       = q_r[rd_ptr_r];
  assign push_ok  = push && !full;
  assign pop_ok   = op_pop && op_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push_ok;
    rd_ptr_nxt = rd_ptr_r ^ pop_ok;
    fill_nxt   = fill_r + 2'(push_ok) - 2'(pop_ok);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

endmodule

// ===== rtl/bfst_back.sv =====
// Back end: count table, read-modify-write of counters and the sorted-walk scan.
module bfst_back
  import bfst_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      op_valid,
  input  bfst_op_t  op,
  output logic      op_pop,
  output logic      out_vld,
  output bfst_out_t out_res,
  input  logic      out_pop
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CNT_WR,
    ST_SCAN,
    ST_DONE
  } state_t;

  state_t                  state_r, state_nxt;
  logic                    started_r, started_nxt;
  logic [COUNT_BITS-1:0]   prev_cnt_r, prev_cnt_nxt;
  logic [SYM_W-1:0]        prev_sym_r, prev_sym_nxt;
  logic [IDX_W-1:0]        scan_idx_r, scan_idx_nxt;
  logic                    pend_r, pend_nxt;
  logic                    f1_r, f1_nxt;
  logic                    f2_r, f2_nxt;
  logic                    out_vld_r, out_vld_nxt;

  logic [KEY_W-1:0]        k1_r, k1_nxt;
  logic [KEY_W-1:0]        k2_r, k2_nxt;
  logic [SYM_W-1:0]        pend_sym_r;
  logic [SYM_W-1:0]        wa_r, wa_nxt;
  bfst_out_t               out_r, out_nxt;

  logic [COUNT_BITS-1:0]   count_mem [SYMBOLS];
  logic [COUNT_BITS-1:0]   rd_data_r;
  logic [SYMBOLS-1:0]      vld_r;
  logic                    rd_vld_r;

  logic [SYM_W-1:0]        rd_addr;
  logic                    mem_we;
  logic [COUNT_BITS-1:0]   wr_data;
  logic [COUNT_BITS-1:0]   cur_cnt;
  logic [KEY_W-1:0]        cur_key;
  logic [KEY_W-1:0]        prev_key;
  logic                    issue;
  logic                    cand;

  assign cur_cnt  = rd_vld_r ? rd_data_r : '0;
  assign cur_key  = {cur_cnt, pend_sym_r};
  assign prev_key = {prev_cnt_r, prev_sym_r};
  assign issue    = (state_r == ST_SCAN) && (scan_idx_r < IDX_W'(SYMBOLS));
  assign cand     = pend_r && (cur_cnt != '0) && (!started_r || (cur_key > prev_key));
  assign rd_addr  = (state_r == ST_IDLE) ? op.sym : scan_idx_r[SYM_W-1:0];

  always_comb begin
    state_nxt    = state_r;
    started_nxt  = started_r;
    prev_cnt_nxt = prev_cnt_r;
    prev_sym_nxt = prev_sym_r;
    scan_idx_nxt = scan_idx_r;
    pend_nxt     = pend_r;
    f1_nxt       = f1_r;
    f2_nxt       = f2_r;
    k1_nxt       = k1_r;
    k2_nxt       = k2_r;
    wa_nxt       = wa_r;
    out_nxt      = out_r;
    out_vld_nxt  = out_vld_r && !out_pop;
    op_pop       = 1'b0;
    mem_we       = 1'b0;
    wr_data      = cur_cnt + 1'b1;

    case (state_r)
      ST_IDLE: begin
        if (op_valid) begin
          op_pop = 1'b1;
          case (op.kind)
            OP_EMIT: begin
              scan_idx_nxt = IDX_W'(1);
              pend_nxt     = 1'b0;
              f1_nxt       = 1'b0;
              f2_nxt       = 1'b0;
              state_nxt    = ST_SCAN;
            end
            OP_COUNT: begin
              wa_nxt       = op.sym;
              started_nxt  = 1'b0;
              prev_cnt_nxt = '0;
              prev_sym_nxt = '0;
              state_nxt    = ST_CNT_WR;
            end
            default: begin
              started_nxt  = 1'b0;
              prev_cnt_nxt = '0;
              prev_sym_nxt = '0;
            end
          endcase
        end
      end
      ST_CNT_WR: begin
        // saturating increment of the counter read last cycle
        mem_we    = (cur_cnt != CNT_MAX);
        state_nxt = ST_IDLE;
      end
      ST_SCAN: begin
        pend_nxt = issue;
        if (issue) begin
          scan_idx_nxt = scan_idx_r + 1'b1;
        end
        // keep the two smallest keys above the previous one
        if (cand) begin
          if (!f1_r || (cur_key < k1_r)) begin
            k2_nxt = k1_r;
            f2_nxt = f1_r;
            k1_nxt = cur_key;
            f1_nxt = 1'b1;
          end else if (!f2_r || (cur_key < k2_r)) begin
            k2_nxt = cur_key;
            f2_nxt = 1'b1;
          end
        end
        if (!issue && !pend_r) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_vld_r || out_pop) begin
          out_vld_nxt = 1'b1;
          if (f1_r) begin
            out_nxt.symbol    = sym_field(k1_r[SYM_W-1:0]);
            out_nxt.count     = cnt_field(k1_r[KEY_W-1:SYM_W]);
            out_nxt.valid_res = 1'b1;
            out_nxt.last      = !f2_r;
            prev_cnt_nxt      = k1_r[KEY_W-1:SYM_W];
            prev_sym_nxt      = k1_r[SYM_W-1:0];
            started_nxt       = 1'b1;
          end else begin
            out_nxt = '0;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      started_r  <= 1'b0;
      prev_cnt_r <= '0;
      prev_sym_r <= '0;
      scan_idx_r <= '0;
      pend_r     <= 1'b0;
      f1_r       <= 1'b0;
      f2_r       <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      started_r  <= started_nxt;
      prev_cnt_r <= prev_cnt_nxt;
      prev_sym_r <= prev_sym_nxt;
      scan_idx_r <= scan_idx_nxt;
      pend_r     <= pend_nxt;
      f1_r       <= f1_nxt;
      f2_r       <= f2_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k1_r       <= k1_nxt;
    k2_r       <= k2_nxt;
    wa_r       <= wa_nxt;
    out_r      <= out_nxt;
    pend_sym_r <= scan_idx_r[SYM_W-1:0];
  end

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (mem_we) begin
        vld_r[wa_r] <= 1'b1;
      end
      rd_vld_r <= vld_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      count_mem[wa_r] <= wr_data;
    end
    rd_data_r <= count_mem[rd_addr];
  end

  assign out_vld = out_vld_r;
  assign out_res = out_r;

  a_second_needs_first: assert property (@(posedge clk) disable iff (!rst_n)
    f2_r |-> f1_r)
    else $error("second-best key held without a best key");

  a_last_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_r.last) |-> out_r.valid_res)
    else $error("last flagged on an empty result");

  a_walk_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    started_r |-> (prev_cnt_r != '0))
    else $error("walk position holds a zero count");

  a_cnt_wr_once: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CNT_WR) |=> (state_r == ST_IDLE))
    else $error("counter update lasted more than one cycle");

endmodule
